FILE: sv/ahcv_pkg.sv
`default_nettype none

package ahcv_pkg;

  // Header layout: nine little-endian words; the header CRC covers the first eight.
  localparam int unsigned HEADER_BYTES   = 36;
  localparam int unsigned HEADER_WORDS   = HEADER_BYTES / 4;
  localparam int unsigned HDR_CRC_BYTES  = HEADER_BYTES - 4;
  localparam int unsigned COUNT_BITS_DEF = 25;
  localparam int unsigned SIZE_BITS      = 25;
  localparam int unsigned WORD_IDX_BITS  = $clog2(HEADER_WORDS);

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

  // Word positions inside the header.
  localparam int unsigned W_MAGIC     = 0;
  localparam int unsigned W_FORMAT    = 1;
  localparam int unsigned W_HDR_SIZE  = 2;
  localparam int unsigned W_UPDATE_ID = 3;
  localparam int unsigned W_TARGET    = 4;
  localparam int unsigned W_IMG_SIZE  = 5;
  localparam int unsigned W_IMG_CRC   = 6;
  localparam int unsigned W_DATA_OFS  = 7;
  localparam int unsigned W_HDR_CRC   = 8;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAGIC    = 2'd0;
  localparam logic [1:0] REG_FORMAT   = 2'd1;
  localparam logic [1:0] REG_DATA_OFS = 2'd2;
  localparam logic [1:0] REG_CAPACITY = 2'd3;

  typedef enum logic [1:0] {
    VERDICT_VALID    = 2'd0,
    VERDICT_HDR_REJ  = 2'd1,
    VERDICT_CRC_FAIL = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       starts_artifact;
  } item_t;

  typedef struct packed {
    logic [1:0]           verdict;
    logic [31:0]          upd_id;
    logic [31:0]          tgt_version;
    logic [SIZE_BITS-1:0] img_len;
  } result_t;

  typedef struct packed {
    logic [31:0]          magic;
    logic [31:0]          format;
    logic [31:0]          data_ofs;
    logic [SIZE_BITS-1:0] capacity;
  } cfg_t;

  typedef logic [HEADER_WORDS-1:0][31:0] hdr_words_t;

  // Reflected CRC-32 update by one byte, bit at a time.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ahcv_cfg_regs.sv
`default_nettype none

module ahcv_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ahcv_pkg::cfg_t     cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        ahcv_pkg::REG_MAGIC:    cfg.magic    <= pwdata;
        ahcv_pkg::REG_FORMAT:   cfg.format   <= pwdata;
        ahcv_pkg::REG_DATA_OFS: cfg.data_ofs <= pwdata;
        ahcv_pkg::REG_CAPACITY: cfg.capacity <= pwdata[ahcv_pkg::SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ahcv_pkg::REG_MAGIC:    prdata = cfg.magic;
      ahcv_pkg::REG_FORMAT:   prdata = cfg.format;
      ahcv_pkg::REG_DATA_OFS: prdata = cfg.data_ofs;
      ahcv_pkg::REG_CAPACITY: prdata = 32'(cfg.capacity);
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/ahcv_hdr_check.sv
`default_nettype none

module ahcv_hdr_check #(
  parameter int unsigned COUNT_BITS = ahcv_pkg::COUNT_BITS_DEF
) (
  input  wire ahcv_pkg::hdr_words_t words,
  input  wire logic [31:0]          hdr_crc_seen,
  input  wire ahcv_pkg::cfg_t       cfg,
  output logic                      ok
);

  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

  logic [31:0] size;

  assign size = words[ahcv_pkg::W_IMG_SIZE];

  // The size must fit both the partition and the byte counter.
  always_comb begin
    ok = (words[ahcv_pkg::W_MAGIC] == cfg.magic)
      && (words[ahcv_pkg::W_FORMAT] == cfg.format)
      && (words[ahcv_pkg::W_HDR_SIZE] == 32'(ahcv_pkg::HEADER_BYTES))
      && (words[ahcv_pkg::W_UPDATE_ID] != '0)
      && (words[ahcv_pkg::W_TARGET] != '0)
      && (size != '0)
      && (words[ahcv_pkg::W_DATA_OFS] == cfg.data_ofs)
      && (words[ahcv_pkg::W_HDR_CRC] == hdr_crc_seen)
      && (size <= 32'(cfg.capacity))
      && ({1'b0, size} <= COUNT_MAX);
  end

endmodule

`default_nettype wire

FILE: sv/ahcv_engine.sv
`default_nettype none

module ahcv_engine #(
  parameter int unsigned COUNT_BITS = ahcv_pkg::COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire ahcv_pkg::item_t   item,
  input  wire ahcv_pkg::cfg_t    cfg,
  output logic                   res_valid,
  output ahcv_pkg::result_t      res
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_IMAGE  = 3'b100
  } phase_t;

  phase_t                  phase, phase_eff, phase_next;
  logic [COUNT_BITS-1:0]   byte_count, count_eff, count_inc, count_next;
  logic [31:0]             running_crc, crc_eff, crc_upd, crc_next;
  logic [31:0]             hdr_crc_seen, hcrc_eff, hcrc_next;
  ahcv_pkg::hdr_words_t    header_words, words_next;
  logic [ahcv_pkg::WORD_IDX_BITS-1:0] word_idx;
  logic [1:0]              lane;
  logic                    hdr_ok;

  // A start byte restarts everything before this byte is handled.
  always_comb begin
    if (item.starts_artifact) begin
      phase_eff = PH_HEADER;
      count_eff = '0;
      crc_eff   = ahcv_pkg::ALL_ONES;
      hcrc_eff  = '0;
    end else begin
      phase_eff = phase;
      count_eff = byte_count;
      crc_eff   = running_crc;
      hcrc_eff  = hdr_crc_seen;
    end
  end

  assign crc_upd   = ahcv_pkg::crc_byte(crc_eff, item.data_byte);
  assign count_inc = count_eff + COUNT_BITS'(1);
  assign word_idx  = count_eff[ahcv_pkg::WORD_IDX_BITS+1:2];
  assign lane      = count_eff[1:0];

  // Header words as they stand once this byte is written in.
  always_comb begin
    words_next = header_words;
    if (phase_eff == PH_HEADER) begin
      for (int i = 0; i < ahcv_pkg::HEADER_WORDS; i++) begin
        if (word_idx == ahcv_pkg::WORD_IDX_BITS'(i)) begin
          words_next[i][8*lane +: 8] = item.data_byte;
        end
      end
    end
  end

  ahcv_hdr_check #(.COUNT_BITS(COUNT_BITS)) u_hdr_check (
    .words        (words_next),
    .hdr_crc_seen (hcrc_eff),
    .cfg          (cfg),
    .ok           (hdr_ok)
  );

  always_comb begin
    phase_next = phase_eff;
    count_next = count_eff;
    crc_next   = crc_eff;
    hcrc_next  = hcrc_eff;
    res_valid  = 1'b0;
    res        = '0;
    res.verdict = ahcv_pkg::VERDICT_HDR_REJ;
    unique case (phase_eff)
      PH_HEADER: begin
        count_next = count_inc;
        if (count_eff < COUNT_BITS'(ahcv_pkg::HDR_CRC_BYTES)) begin
          crc_next = crc_upd;
        end
        if (count_inc == COUNT_BITS'(ahcv_pkg::HDR_CRC_BYTES)) begin
          hcrc_next = crc_upd ^ ahcv_pkg::ALL_ONES;
        end
        if (count_inc == COUNT_BITS'(ahcv_pkg::HEADER_BYTES)) begin
          count_next = '0;
          if (!hdr_ok) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
          end else begin
            phase_next = PH_IMAGE;
            crc_next   = ahcv_pkg::ALL_ONES;
          end
        end
      end
      PH_IMAGE: begin
        crc_next   = crc_upd;
        count_next = count_inc;
        if (32'(count_inc) == header_words[ahcv_pkg::W_IMG_SIZE]) begin
          phase_next = PH_IDLE;
          count_next = '0;
          res_valid  = 1'b1;
          if ((crc_upd ^ ahcv_pkg::ALL_ONES) == header_words[ahcv_pkg::W_IMG_CRC]) begin
            res.verdict     = ahcv_pkg::VERDICT_VALID;
            res.upd_id      = header_words[ahcv_pkg::W_UPDATE_ID];
            res.tgt_version = header_words[ahcv_pkg::W_TARGET];
            res.img_len     =
              header_words[ahcv_pkg::W_IMG_SIZE][ahcv_pkg::SIZE_BITS-1:0];
          end else begin
            res.verdict = ahcv_pkg::VERDICT_CRC_FAIL;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_count   <= '0;
      running_crc  <= ahcv_pkg::ALL_ONES;
      hdr_crc_seen <= '0;
    end else if (step) begin
      phase        <= phase_next;
      byte_count   <= count_next;
      running_crc  <= crc_next;
      hdr_crc_seen <= hcrc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      header_words <= words_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/artifact_header_and_crc_verifier_unit.sv
`default_nettype none

// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_ready     ahcv_pkg::item_t (data_byte, starts_artifact)
// result    out        result_valid / result_ready ahcv_pkg::result_t (verdict, id, version, size)
// config    in         APB psel/penable/pwrite     paddr[3:2] selects one of four registers
//
// One byte is taken per cycle while no result waits: the eight-step CRC update fits between
// the input register and the state and result registers. A result, when a byte causes one,
// is registered in the result register as that byte leaves the input register.
// Reset clears the phase, the counter and the CRC state; header words are not reset.
// While a result waits, the byte in the input register holds, whether or not it
// would cause a result, and with a byte held, item_ready drops until the result is taken.

module artifact_header_and_crc_verifier_unit #(
  parameter int unsigned COUNT_BITS = ahcv_pkg::COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire ahcv_pkg::item_t    item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output ahcv_pkg::result_t       result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  ahcv_pkg::cfg_t     cfg;
  ahcv_pkg::item_t    item_reg;
  logic               item_reg_valid;
  logic               advance;
  logic               eng_valid;
  ahcv_pkg::result_t  eng_res;

  ahcv_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held byte moves into the engine whenever the result register has room,
  // or is being emptied in this same cycle.
  assign advance    = item_reg_valid && (!result_valid || result_ready);
  assign item_ready = !item_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg_valid <= 1'b0;
    end else if (item_ready) begin
      item_reg_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_reg <= item;
    end
  end

  ahcv_engine #(.COUNT_BITS(COUNT_BITS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (item_reg),
    .cfg       (cfg),
    .res_valid (eng_valid),
    .res       (eng_res)
  );

  // Result register. A new verdict only lands when the old one is gone or leaving.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && eng_valid) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && eng_valid) begin
      result <= eng_res;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Self-checking testbench for the artifact header and CRC verifier.
//
// Stimulus is built as whole artifacts: a 36-byte header of nine little-endian
// words followed by the image bytes. Every accepted byte also goes through a
// scoreboard-side model of the verifier, which keeps its own copy of the scan
// phase, byte counter, header words, CRC state and register values. When that
// model reaches a verdict it queues the expected result. The monitor compares
// each result transaction against the oldest queued verdict, field by field.
module tb;
  import ahcv_pkg::*;

  localparam int unsigned LIMIT_CYCLES    = 400000;
  localparam int unsigned QUIET_CYCLES    = 8;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned ITEMS_TOTAL     = 1300;
  localparam int unsigned IMAGE_BUILD_MAX = 2048;
  localparam int unsigned ALL_BYTES       = 32'hFFFF_FFFF;
  localparam logic [31:0] CAPACITY_MAX    = 32'h0100_0000;

  // Where the scoreboard model is within the current artifact.
  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_HEADER,
    SCAN_IMAGE
  } scan_phase_t;

  // Ways of spoiling a generated artifact. The header faults sit between
  // FAULT_MAGIC and FAULT_OVERSIZE so that one can be picked at random.
  typedef enum int {
    FAULT_NONE,
    FAULT_MAGIC,
    FAULT_FORMAT,
    FAULT_HDR_SIZE,
    FAULT_ZERO_ID,
    FAULT_ZERO_TARGET,
    FAULT_ZERO_SIZE,
    FAULT_DATA_OFS,
    FAULT_HDR_CRC,
    FAULT_OVERSIZE,
    FAULT_IMG_CRC
  } frame_fault_t;

  // Stall styles of the result receiver.
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_SLOW_BLOCKS
  } rx_style_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  item_t       item         = '0;
  logic        item_ready;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [3:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  // Scoreboard model state and the register values it checks against.
  scan_phase_t                scan_phase      = SCAN_IDLE;
  logic [COUNT_BITS_DEF-1:0]  scan_count      = '0;
  logic [31:0]                seen_words [HEADER_WORDS];
  logic [31:0]                crc_acc         = '1;
  logic [31:0]                header_crc_calc = '0;
  cfg_t                       cfg_now         = '0;
  result_t                    verdicts_due [$];
  result_t                    due;

  // The artifact currently being generated.
  logic [31:0] frame_words [HEADER_WORDS];
  logic [7:0]  frame_image [$];

  int unsigned errors          = 0;
  int unsigned sent_items      = 0;
  int unsigned results_checked = 0;
  int unsigned cycle_count     = 0;
  int unsigned burst_left      = 0;
  bit          hold_request    = 1'b0;
  int unsigned hold_left       = 0;
  rx_style_t   rx_style        = RX_ALWAYS;
  int unsigned rx_left         = 0;

  artifact_header_and_crc_verifier_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reflected CRC-32, one input bit at a time folded into the feedback term.
  function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Header acceptance rules, applied once the last header byte has arrived.
  function automatic logic header_passes();
    logic [31:0] img_size;
    img_size = seen_words[W_IMG_SIZE];
    return seen_words[W_MAGIC] == cfg_now.magic &&
           seen_words[W_FORMAT] == cfg_now.format &&
           seen_words[W_HDR_SIZE] == HEADER_BYTES &&
           seen_words[W_UPDATE_ID] != 0 &&
           seen_words[W_TARGET] != 0 &&
           img_size != 0 &&
           seen_words[W_DATA_OFS] == cfg_now.data_ofs &&
           seen_words[W_HDR_CRC] == header_crc_calc &&
           img_size <= 32'(cfg_now.capacity) &&
           img_size < (32'd1 << COUNT_BITS_DEF);
  endfunction

  // Only a passing artifact reports its id, version and size; the rest read zero.
  function automatic result_t verdict_for(verdict_t v);
    result_t r;
    r = '0;
    r.verdict = v;
    if (v == VERDICT_VALID) begin
      r.upd_id      = seen_words[W_UPDATE_ID];
      r.tgt_version = seen_words[W_TARGET];
      r.img_len     = seen_words[W_IMG_SIZE][SIZE_BITS-1:0];
    end
    return r;
  endfunction

  // Advance the scoreboard model by one accepted byte. A start flag throws
  // away whatever artifact was in progress, without a verdict.
  task automatic predict_byte(input logic [7:0] b, input logic st);
    int unsigned wi;
    if (st) begin
      scan_phase      = SCAN_HEADER;
      scan_count      = '0;
      crc_acc         = '1;
      header_crc_calc = '0;
    end
    case (scan_phase)
      SCAN_HEADER: begin
        wi = scan_count >> 2;
        seen_words[wi][8*scan_count[1:0] +: 8] = b;
        if (scan_count < HDR_CRC_BYTES) crc_acc = crc_update(crc_acc, b);
        scan_count = scan_count + 1'b1;
        if (scan_count == HDR_CRC_BYTES) header_crc_calc = ~crc_acc;
        if (scan_count == HEADER_BYTES) begin
          scan_count = '0;
          if (header_passes()) begin
            scan_phase = SCAN_IMAGE;
            crc_acc    = '1;
          end else begin
            scan_phase = SCAN_IDLE;
            verdicts_due.push_back(verdict_for(VERDICT_HDR_REJ));
          end
        end
      end
      SCAN_IMAGE: begin
        crc_acc    = crc_update(crc_acc, b);
        scan_count = scan_count + 1'b1;
        if (32'(scan_count) == seen_words[W_IMG_SIZE]) begin
          scan_phase = SCAN_IDLE;
          scan_count = '0;
          verdicts_due.push_back(verdict_for((~crc_acc == seen_words[W_IMG_CRC]) ?
                                             VERDICT_VALID : VERDICT_CRC_FAIL));
        end
      end
      default: ;
    endcase
  endtask

  // Offer one byte. The sender works in bursts; between bursts valid drops for
  // a random gap, and about a third of the bursts follow on with no gap at all.
  task automatic send_byte(input logic [7:0] b, input logic st);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    item_valid <= 1'b1;
    item       <= '{data_byte: b, starts_artifact: st};
    do @(posedge clk); while (!item_ready);
    burst_left--;
    sent_items++;
    predict_byte(b, st);
  endtask

  // Stop offering bytes and let every expected result drain out. The extra
  // cycles cover bytes still in the pipeline that produce no result.
  task automatic wait_quiet();
    item_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] want;
    want = (idx == REG_CAPACITY) ? 32'(value[SIZE_BITS-1:0]) : value;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d read back expected %h, got %h", $time, idx, want, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MAGIC:    cfg_now.magic    = value;
      REG_FORMAT:   cfg_now.format   = value;
      REG_DATA_OFS: cfg_now.data_ofs = value;
      REG_CAPACITY: cfg_now.capacity = value[SIZE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] magic, fmt, ofs, cap);
    wait_quiet();
    write_register(REG_MAGIC, magic);
    write_register(REG_FORMAT, fmt);
    write_register(REG_DATA_OFS, ofs);
    write_register(REG_CAPACITY, cap);
  endtask

  function automatic logic [7:0] frame_byte(int unsigned k);
    return frame_words[k / 4][8*(k % 4) +: 8];
  endfunction

  // Image sizes that the current capacity admits; capacity zero admits none,
  // so a size of one is used and the header is rejected.
  function automatic int unsigned fit_size(int unsigned want);
    if (cfg_now.capacity == 0) return 1;
    return (want > cfg_now.capacity) ? cfg_now.capacity : want;
  endfunction

  // Build a header that matches the current registers plus a random image,
  // then apply the requested fault. Huge sizes only get the first bytes built,
  // since such an artifact is always cut short by a restart.
  task automatic build_frame(input logic [31:0] img_size, input frame_fault_t fault);
    logic [31:0] c;
    int unsigned bit_pos;
    bit_pos = $urandom_range(0, 31);
    frame_words[W_MAGIC]     = cfg_now.magic;
    frame_words[W_FORMAT]    = cfg_now.format;
    frame_words[W_HDR_SIZE]  = HEADER_BYTES;
    frame_words[W_UPDATE_ID] = $urandom | (32'd1 << $urandom_range(0, 31));
    frame_words[W_TARGET]    = $urandom | (32'd1 << $urandom_range(0, 31));
    frame_words[W_IMG_SIZE]  = img_size;
    frame_words[W_DATA_OFS]  = cfg_now.data_ofs;
    frame_image.delete();
    c = '1;
    for (int unsigned k = 0; k < img_size && k < IMAGE_BUILD_MAX; k++) begin
      frame_image.push_back(8'($urandom));
      c = crc_update(c, frame_image[k]);
    end
    frame_words[W_IMG_CRC] = ~c;
    case (fault)
      FAULT_MAGIC:       frame_words[W_MAGIC]     ^= 32'd1 << bit_pos;
      FAULT_FORMAT:      frame_words[W_FORMAT]    ^= 32'd1 << bit_pos;
      FAULT_HDR_SIZE:    frame_words[W_HDR_SIZE]  ^= 32'd1 << bit_pos;
      FAULT_ZERO_ID:     frame_words[W_UPDATE_ID] = '0;
      FAULT_ZERO_TARGET: frame_words[W_TARGET]    = '0;
      FAULT_ZERO_SIZE:   frame_words[W_IMG_SIZE]  = '0;
      FAULT_DATA_OFS:    frame_words[W_DATA_OFS]  ^= 32'd1 << bit_pos;
      FAULT_IMG_CRC:     frame_words[W_IMG_CRC]   ^= 32'd1 << bit_pos;
      // Either one past the capacity, or beyond what the byte counter can hold.
      FAULT_OVERSIZE:
        frame_words[W_IMG_SIZE] = $urandom_range(0, 1) ? 32'(cfg_now.capacity) + 32'd1 :
                                                        ($urandom | 32'h0200_0000);
      default: ;
    endcase
    c = '1;
    for (int unsigned k = 0; k < HDR_CRC_BYTES; k++) c = crc_update(c, frame_byte(k));
    frame_words[W_HDR_CRC] = (fault == FAULT_HDR_CRC) ? (~c ^ (32'd1 << bit_pos)) : ~c;
    // A rejected header ends the artifact, so no image follows it.
    if (fault != FAULT_NONE && fault != FAULT_IMG_CRC) frame_image.delete();
  endtask

  // Send the built artifact, or only its first keep bytes.
  task automatic send_frame(input int unsigned keep);
    int unsigned total;
    total = HEADER_BYTES + frame_image.size();
    if (keep < total) total = keep;
    for (int unsigned k = 0; k < total; k++)
      send_byte((k < HEADER_BYTES) ? frame_byte(k) : frame_image[k - HEADER_BYTES], k == 0);
  endtask

  // Register extremes. With everything zero, capacity zero rejects any header.
  // With all-ones match words and the largest capacity, artifacts pass, a long
  // image runs the counter past eight bits, and a header naming the
  // largest image is accepted and then abandoned by a restart.
  task automatic test_register_extremes();
    set_config('0, '0, '0, '0);
    build_frame(1, FAULT_NONE);
    send_frame(ALL_BYTES);
    build_frame(1, FAULT_OVERSIZE);
    send_frame(ALL_BYTES);
    set_config('1, '1, '1, CAPACITY_MAX);
    build_frame(3, FAULT_NONE);
    send_frame(ALL_BYTES);
    build_frame(260, FAULT_NONE);
    send_frame(ALL_BYTES);
    build_frame(CAPACITY_MAX, FAULT_NONE);
    send_frame(HEADER_BYTES + 5);
    build_frame(1, FAULT_NONE);
    send_frame(ALL_BYTES);
  endtask

  // Each header rule broken on its own, the image CRC broken, and a size that
  // sits exactly at the capacity.
  task automatic test_header_checks();
    set_config(32'h5A17_C0DE, 32'd2, 32'h0000_1000, 32'd20);
    build_frame(20, FAULT_NONE);
    send_frame(ALL_BYTES);
    for (int f = FAULT_MAGIC; f <= FAULT_IMG_CRC; f++) begin
      build_frame(5, frame_fault_t'(f));
      send_frame(ALL_BYTES);
    end
  endtask

  // Bytes with no artifact in progress are dropped, and a start flag abandons
  // an artifact early in its header, just before its last header byte, or in its image.
  task automatic test_idle_and_restart();
    repeat (3) send_byte(8'($urandom), 1'b0);
    build_frame(8, FAULT_NONE);
    send_frame(10);
    build_frame(8, FAULT_NONE);
    send_frame(HEADER_BYTES - 1);
    build_frame(8, FAULT_NONE);
    send_frame(HEADER_BYTES + 4);
    build_frame(8, FAULT_NONE);
    send_frame(ALL_BYTES);
    repeat (2) send_byte(8'($urandom), 1'b0);
  endtask

  // The receiver holds off for a long stretch while short artifacts keep
  // coming, so results back up and the block has to stall its input.
  task automatic test_full_backpressure();
    hold_request = 1'b1;
    repeat (2) begin
      build_frame(2, FAULT_MAGIC);
      send_frame(ALL_BYTES);
    end
    build_frame(2, FAULT_NONE);
    send_frame(ALL_BYTES);
  endtask

  // Mostly well-formed artifacts with random content, plus corrupted headers,
  // bad image CRCs, truncated artifacts and stray bytes, until the overall byte
  // budget is spent. The registers change every hundred or so bytes, but only
  // between artifacts.
  task automatic test_random_stream();
    int unsigned since_cfg;
    int unsigned pick;
    since_cfg = sent_items;
    while (sent_items < ITEMS_TOTAL) begin
      if (sent_items - since_cfg > 80 && scan_phase == SCAN_IDLE) begin
        set_config($urandom, $urandom, $urandom,
                   ($urandom_range(0, 3) == 0) ? CAPACITY_MAX : $urandom_range(1, 40));
        since_cfg = sent_items;
      end
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        build_frame(fit_size($urandom_range(1, 24)), FAULT_NONE);
        send_frame(ALL_BYTES);
      end else if (pick < 70) begin
        build_frame(fit_size($urandom_range(1, 24)), FAULT_IMG_CRC);
        send_frame(ALL_BYTES);
      end else if (pick < 84) begin
        build_frame(fit_size($urandom_range(1, 24)),
                    frame_fault_t'($urandom_range(FAULT_MAGIC, FAULT_OVERSIZE)));
        send_frame(ALL_BYTES);
      end else if (pick < 95) begin
        build_frame(fit_size($urandom_range(1, 24)), FAULT_NONE);
        send_frame($urandom_range(1, HEADER_BYTES + frame_image.size() - 1));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // Result receiver. A long hold-off, when requested, wins over everything;
  // otherwise the stall style is picked anew at random for each stretch.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style = rx_style_t'($urandom_range(RX_ALWAYS, RX_SLOW_BLOCKS));
        rx_left  = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_style)
        RX_ALWAYS:      result_ready <= 1'b1;
        RX_COIN:        result_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:      result_ready <= ($urandom_range(0, 3) == 0);
        RX_SLOW_BLOCKS: result_ready <= rx_left[2];
        default:        result_ready <= 1'b1;
      endcase
    end
  end

  task automatic report_field(input string field, input logic [31:0] want, got);
    $display("%0t: %s expected %h, got %h", $time, field, want, got);
    errors++;
  endtask

  // Result monitor: every result transaction must match the oldest verdict due.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result, verdict %0d id %h version %h size %h", $time,
                 result.verdict, result.upd_id, result.tgt_version, result.img_len);
        errors++;
      end else begin
        due = verdicts_due.pop_front();
        if (result.verdict !== due.verdict)
          report_field("verdict", 32'(due.verdict), 32'(result.verdict));
        if (result.upd_id !== due.upd_id)
          report_field("upd_id", due.upd_id, result.upd_id);
        if (result.tgt_version !== due.tgt_version)
          report_field("tgt_version", due.tgt_version, result.tgt_version);
        if (result.img_len !== due.img_len)
          report_field("img_len", 32'(due.img_len), 32'(result.img_len));
        results_checked++;
      end
    end
  end

  // Watchdog for a block that hangs or never answers.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_extremes();
    test_header_checks();
    test_idle_and_restart();
    test_full_backpressure();
    test_random_stream();
    wait_quiet();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ahcv_pkg.sv
sv/ahcv_cfg_regs.sv
sv/ahcv_hdr_check.sv
sv/ahcv_engine.sv
sv/artifact_header_and_crc_verifier_unit.sv
tb/tb.sv
